/* rtl/edf_deadline_scheduler_macros.svh */
// Assertion helpers for the deadline scheduler.
// Each macro expects clk and rst_n in scope.
`ifndef EDF_DEADLINE_SCHEDULER_MACROS_SVH
`define EDF_DEADLINE_SCHEDULER_MACROS_SVH

// Same-cycle implication.
`define EDF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define EDF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/edf_pkg.sv */
`default_nettype none

package edf_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 8;
    localparam int TICK_W      = 32;
    localparam int EXEC_W      = 16;
    localparam int TOTAL_W     = 16;

    // Command codes
    localparam logic [1:0] CMD_RELEASE  = 2'd0;
    localparam logic [1:0] CMD_COMPLETE = 2'd1;
    localparam logic [1:0] CMD_POLL     = 2'd2;

    // Cell operations
    typedef logic [1:0] cell_op_t;
    localparam cell_op_t OP_HOLD   = 2'd0;
    localparam cell_op_t OP_POP    = 2'd1;
    localparam cell_op_t OP_INSERT = 2'd2;

    typedef struct packed {
        logic [1:0]        command;
        logic [ID_W-1:0]   task_id;
        logic [TICK_W-1:0] deadline;
        logic [EXEC_W-1:0] exec_time;
        logic [TICK_W-1:0] now;
    } cmd_t;

    typedef struct packed {
        logic               head_valid;
        logic [ID_W-1:0]    head_id;
        logic               preempted;
        logic               rejected_late;
        logic               expired;
        logic [ID_W-1:0]    expired_id;
        logic               finished;
        logic [ID_W-1:0]    finished_id;
        logic               full_drop;
        logic [CNT_W-1:0]   active_count;
        logic [TOTAL_W-1:0] completed_count;
        logic [TOTAL_W-1:0] overdue_count;
    } res_t;

    typedef struct packed {
        logic [TICK_W-1:0] deadline;
        logic [ID_W-1:0]   task_id;
    } slot_t;

    typedef struct packed {
        cell_op_t          op;
        logic [TICK_W-1:0] deadline;
        logic [ID_W-1:0]   task_id;
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/edf_cell.sv */
`default_nettype none

module edf_cell (
    input  wire logic               clk,
    input  wire edf_pkg::cell_ctrl_t ctrl,
    input  wire logic               occupied,
    input  wire edf_pkg::slot_t     left_slot,
    input  wire logic               left_here,
    input  wire edf_pkg::slot_t     right_slot,
    output edf_pkg::slot_t          slot,
    output logic                    here
);

    edf_pkg::slot_t slot_reg;
    edf_pkg::slot_t slot_next;

    // New task belongs at or before this cell: empty, or strictly earlier deadline
    assign here = !occupied || (ctrl.deadline < slot_reg.deadline);
    assign slot = slot_reg;

    // Shift toward head on pop, away from head on insert
    always_comb
    begin
        slot_next = slot_reg;
        unique case (ctrl.op)
            edf_pkg::OP_POP:
            begin
                slot_next = right_slot;
            end
            edf_pkg::OP_INSERT:
            begin
                if (left_here)
                begin
                    slot_next = left_slot;
                end
                else if (here)
                begin
                    slot_next.deadline = ctrl.deadline;
                    slot_next.task_id  = ctrl.task_id;
                end
            end
            default:
            begin
                slot_next = slot_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

`default_nettype wire

/* rtl/edf_deadline_scheduler.sv */
// Earliest-deadline-first scheduler.
// Request channel: cmd_valid / cmd_ready carry one event (release, complete,
// poll) with its task fields and the current tick in cmd.
// Result channel: res_valid / res_ready carry one result per event: the head
// after the event, the flags of what happened and the running counters.
// Timing: in the cycle in which an event is taken, an overdue head is
// dropped against cmd.now; the command runs in state S_CMD once the output
// register is free, and its result lands in that register. A new event is
// taken only after the previous command has run. The rate is set by the
// two shifts of the cell chain per event (expiry pop, then command).
// The queue is a chain of QUEUE_DEPTH cells, head in cell 0; each cell shifts
// to its neighbor on pop or insert, so sorting needs no separate pass.
// Reset clears the queue length, both counters, the state and res_valid.
// Slot contents need no clearing. While res_ready is low a finished result
// holds in the output register; the next event may still be taken and its
// expiry pass done, and its command waits until the register frees up.
`default_nettype none
`include "edf_deadline_scheduler_macros.svh"

module edf_deadline_scheduler (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire edf_pkg::cmd_t cmd,
    output logic               res_valid,
    input  wire logic          res_ready,
    output edf_pkg::res_t      res
);

    localparam int DEPTH = edf_pkg::QUEUE_DEPTH;
    localparam int CW    = edf_pkg::CNT_W;
    localparam int TW    = edf_pkg::TOTAL_W;
    localparam logic S_IDLE = 1'b0;
    localparam logic S_CMD  = 1'b1;

    logic                      state_reg, state_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [TW-1:0]             done_reg, done_next;
    logic [TW-1:0]             late_reg, late_next;
    edf_pkg::cmd_t             req_reg;
    logic                      exp_reg;
    logic [edf_pkg::ID_W-1:0]  exp_id_reg;
    logic                      res_valid_reg, res_valid_next;
    edf_pkg::res_t             res_reg, res_next;

    edf_pkg::cell_ctrl_t       ctrl;
    edf_pkg::slot_t            slot_q [DEPTH];
    logic [DEPTH-1:0]          here_q;
    logic [DEPTH-1:0]          occ_q;

    logic                      accept;
    logic                      expire_now;
    logic                      out_free;
    logic                      late;
    logic                      full;

    // Cell chain
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(i);
        edf_pkg::slot_t left_s, right_s;
        logic           left_h;

        assign occ_q[i] = IDX < count_reg;
        if (i == 0)
        begin : g_first
            assign left_s = '0;
            assign left_h = 1'b0;
        end
        else
        begin : g_mid
            assign left_s = slot_q[i-1];
            assign left_h = here_q[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign right_s = '0;
        end
        else
        begin : g_inner
            assign right_s = slot_q[i+1];
        end

        edf_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .occupied   (occ_q[i]),
            .left_slot  (left_s),
            .left_here  (left_h),
            .right_slot (right_s),
            .slot       (slot_q[i]),
            .here       (here_q[i])
        );
    end

    assign cmd_ready  = state_reg == S_IDLE;
    assign accept     = cmd_valid && cmd_ready;
    assign expire_now = accept && (count_reg != '0) && (slot_q[0].deadline < cmd.now);
    assign out_free   = !res_valid_reg || res_ready;
    assign late       = {1'b0, req_reg.deadline}
                        < ({1'b0, req_reg.now} + (edf_pkg::TICK_W + 1)'(req_reg.exec_time));
    assign full       = count_reg == CW'(DEPTH);

    // Sequence the expiry pass and the command, build the result
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        done_next      = done_reg;
        late_next      = late_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        ctrl.op        = edf_pkg::OP_HOLD;
        ctrl.deadline  = req_reg.deadline;
        ctrl.task_id   = req_reg.task_id;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CMD;
                    if (expire_now)
                    begin
                        ctrl.op    = edf_pkg::OP_POP;
                        count_next = count_reg - CW'(1);
                        late_next  = (late_reg == '1) ? late_reg : late_reg + TW'(1);
                    end
                end
            end
            S_CMD:
            begin
                if (out_free)
                begin
                    state_next             = S_IDLE;
                    res_valid_next         = 1'b1;
                    res_next               = '0;
                    res_next.expired       = exp_reg;
                    res_next.expired_id    = exp_reg ? exp_id_reg : '0;
                    res_next.head_id       = slot_q[0].task_id;
                    case (req_reg.command)
                        edf_pkg::CMD_RELEASE:
                        begin
                            if (late)
                            begin
                                res_next.rejected_late = 1'b1;
                                late_next = (late_reg == '1) ? late_reg : late_reg + TW'(1);
                            end
                            else if (full)
                            begin
                                res_next.full_drop = 1'b1;
                            end
                            else
                            begin
                                ctrl.op    = edf_pkg::OP_INSERT;
                                count_next = count_reg + CW'(1);
                                res_next.preempted = (count_reg != '0) && here_q[0];
                                if (here_q[0])
                                begin
                                    res_next.head_id = req_reg.task_id;
                                end
                            end
                        end
                        edf_pkg::CMD_COMPLETE:
                        begin
                            if (count_reg != '0)
                            begin
                                ctrl.op              = edf_pkg::OP_POP;
                                count_next           = count_reg - CW'(1);
                                res_next.finished    = 1'b1;
                                res_next.finished_id = slot_q[0].task_id;
                                res_next.head_id     = slot_q[1].task_id;
                                done_next = (done_reg == '1) ? done_reg : done_reg + TW'(1);
                            end
                        end
                        default:
                        begin
                            // poll only: expiry already done
                        end
                    endcase
                    res_next.head_valid      = count_next != '0;
                    if (count_next == '0)
                    begin
                        res_next.head_id = '0;
                    end
                    res_next.active_count    = count_next;
                    res_next.completed_count = done_next;
                    res_next.overdue_count   = late_next;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            done_reg      <= '0;
            late_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            late_reg      <= late_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Capture the request and the expiry outcome, hold the result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg    <= cmd;
            exp_reg    <= expire_now;
            exp_id_reg <= slot_q[0].task_id;
        end
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `EDF_ASSERT_IMP(a_count_range, 1'b1, count_reg <= CW'(DEPTH), "queue length beyond depth")
    `EDF_ASSERT_NXT(a_expire_pop, expire_now, count_reg == $past(count_reg) - CW'(1), "expiry did not pop")
    `EDF_ASSERT_IMP(a_res_source, $rose(res_valid), $past(state_reg) == S_CMD, "result without command")
    `EDF_ASSERT_IMP(a_drop_full, res_valid && res.full_drop, res.active_count == CW'(DEPTH), "drop while not full")
    `EDF_ASSERT_IMP(a_head_count, res_valid, res.head_valid == (res.active_count != '0), "head flag mismatch")

endmodule

`default_nettype wire

/* tb/edf_deadline_scheduler_tb.sv */
`timescale 1ns / 1ps

module edf_deadline_scheduler_tb;

    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam int PHASE_COUNT = 18;
    localparam int PHASE_ITEMS = 100;
    localparam int MAX_REPORTS = 10;
    localparam int SETTLE_CYCLES = 10;

    // Spare command code: behaves as a poll
    localparam logic [1:0] CMD_SPARE = 2'd3;

    // Tracks the deadline queue and the expected result of every accepted request
    class schedule_tracker;
        logic [edf_pkg::TICK_W-1:0]  line_deadline[edf_pkg::QUEUE_DEPTH];
        logic [edf_pkg::ID_W-1:0]    line_id[edf_pkg::QUEUE_DEPTH];
        int                          line_len = 0;
        logic [edf_pkg::TOTAL_W-1:0] done_tally = '0;
        logic [edf_pkg::TOTAL_W-1:0] late_tally = '0;
        edf_pkg::res_t               expected_results[$];
        int                          mismatches = 0;

        function int pending();
            return expected_results.size();
        endfunction

        function logic [edf_pkg::TOTAL_W-1:0] bump(logic [edf_pkg::TOTAL_W-1:0] v);
            return (v == '1) ? v : v + 1'b1;
        endfunction

        function void drop_head();
            int i;
            for (i = 0; i + 1 < line_len; i++)
            begin
                line_deadline[i] = line_deadline[i + 1];
                line_id[i]       = line_id[i + 1];
            end
            line_len--;
        endfunction

        function edf_pkg::res_t predict_event(edf_pkg::cmd_t c);
            edf_pkg::res_t              r;
            int                         pos;
            int                         i;
            logic [edf_pkg::TICK_W:0]   reach;
            r = '0;
            // Retire an overdue head before the command runs
            if (line_len > 0 && line_deadline[0] < c.now)
            begin
                r.expired    = 1'b1;
                r.expired_id = line_id[0];
                drop_head();
                late_tally = bump(late_tally);
            end
            case (c.command)
                edf_pkg::CMD_RELEASE:
                begin
                    // Lateness sum is formed one bit wider so it cannot wrap
                    reach = {1'b0, c.now} + (edf_pkg::TICK_W + 1)'(c.exec_time);
                    if ({1'b0, c.deadline} < reach)
                    begin
                        r.rejected_late = 1'b1;
                        late_tally = bump(late_tally);
                    end
                    else if (line_len >= edf_pkg::QUEUE_DEPTH)
                        r.full_drop = 1'b1;
                    else
                    begin
                        // Equal deadlines keep arrival order
                        pos = 0;
                        while (pos < line_len && !(c.deadline < line_deadline[pos]))
                            pos++;
                        if (line_len > 0 && pos == 0)
                            r.preempted = 1'b1;
                        for (i = line_len; i > pos; i--)
                        begin
                            line_deadline[i] = line_deadline[i - 1];
                            line_id[i]       = line_id[i - 1];
                        end
                        line_deadline[pos] = c.deadline;
                        line_id[pos]       = c.task_id;
                        line_len++;
                    end
                end
                edf_pkg::CMD_COMPLETE:
                begin
                    if (line_len > 0)
                    begin
                        r.finished    = 1'b1;
                        r.finished_id = line_id[0];
                        drop_head();
                        done_tally = bump(done_tally);
                    end
                end
                default: ;
            endcase
            r.head_valid      = (line_len > 0);
            r.head_id         = (line_len > 0) ? line_id[0] : '0;
            r.active_count    = (edf_pkg::CNT_W)'(line_len);
            r.completed_count = done_tally;
            r.overdue_count   = late_tally;
            return r;
        endfunction

        function void note_request(edf_pkg::cmd_t c);
            expected_results.push_back(predict_event(c));
        endfunction

        function void match_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(edf_pkg::res_t got);
            edf_pkg::res_t want;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result %h with no request pending", $time, got);
                return;
            end
            want = expected_results.pop_front();
            match_field("head_valid", 32'(want.head_valid), 32'(got.head_valid));
            match_field("head_id", 32'(want.head_id), 32'(got.head_id));
            match_field("preempted", 32'(want.preempted), 32'(got.preempted));
            match_field("rejected_late", 32'(want.rejected_late), 32'(got.rejected_late));
            match_field("expired", 32'(want.expired), 32'(got.expired));
            match_field("expired_id", 32'(want.expired_id), 32'(got.expired_id));
            match_field("finished", 32'(want.finished), 32'(got.finished));
            match_field("finished_id", 32'(want.finished_id), 32'(got.finished_id));
            match_field("full_drop", 32'(want.full_drop), 32'(got.full_drop));
            match_field("active_count", 32'(want.active_count), 32'(got.active_count));
            match_field("completed_count", 32'(want.completed_count),
                        32'(got.completed_count));
            match_field("overdue_count", 32'(want.overdue_count), 32'(got.overdue_count));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cmd_valid;
    logic cmd_ready;
    edf_pkg::cmd_t cmd;
    logic res_valid;
    logic res_ready;
    edf_pkg::res_t res;

    schedule_tracker tracker = new();

    logic [edf_pkg::TICK_W-1:0] tick;
    logic [edf_pkg::TICK_W-1:0] last_deadline;
    logic                       no_idle = 1'b0;
    int unsigned                cycle_count = 0;

    edf_deadline_scheduler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** edf_deadline_scheduler: FAILED **");
            $finish;
        end
    end

    function automatic edf_pkg::cmd_t make_request(logic [1:0] op,
                                                   logic [edf_pkg::ID_W-1:0] id,
                                                   logic [edf_pkg::TICK_W-1:0] dl,
                                                   logic [edf_pkg::EXEC_W-1:0] ex,
                                                   logic [edf_pkg::TICK_W-1:0] at);
        edf_pkg::cmd_t c;
        c.command   = op;
        c.task_id   = id;
        c.deadline  = dl;
        c.exec_time = ex;
        c.now       = at;
        return c;
    endfunction

    // Build one event of a plausible schedule, with some noise mixed in
    function automatic edf_pkg::cmd_t next_event(int release_pct, int step_max);
        int                         roll;
        logic [edf_pkg::EXEC_W-1:0] ex;
        logic [edf_pkg::TICK_W-1:0] dl;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return make_request(2'($urandom_range(0, 3)), (edf_pkg::ID_W)'($urandom),
                                $urandom, (edf_pkg::EXEC_W)'($urandom), $urandom);
        tick = tick + (edf_pkg::TICK_W)'($urandom_range(0, step_max));
        if (roll < 8 + release_pct)
        begin
            ex = ($urandom_range(0, 9) == 0) ? (edf_pkg::EXEC_W)'($urandom)
                                             : (edf_pkg::EXEC_W)'($urandom_range(0, 200));
            if ($urandom_range(0, 9) == 0)
                dl = tick + (edf_pkg::TICK_W)'(ex)
                     - (edf_pkg::TICK_W)'(1 + $urandom_range(0, 50));
            else if ($urandom_range(0, 6) == 0)
                dl = last_deadline;
            else
                dl = tick + (edf_pkg::TICK_W)'(ex)
                     + (edf_pkg::TICK_W)'($urandom_range(0, 600));
            last_deadline = dl;
            return make_request(edf_pkg::CMD_RELEASE, (edf_pkg::ID_W)'($urandom), dl, ex,
                                tick);
        end
        if ($urandom_range(0, 9) < 7)
            return make_request(edf_pkg::CMD_COMPLETE, (edf_pkg::ID_W)'($urandom), $urandom,
                                (edf_pkg::EXEC_W)'($urandom), tick);
        return make_request(($urandom_range(0, 3) == 0) ? CMD_SPARE : edf_pkg::CMD_POLL,
                            (edf_pkg::ID_W)'($urandom), $urandom,
                            (edf_pkg::EXEC_W)'($urandom), tick);
    endfunction

    // Offer one request after a random gap and hold it until taken
    task automatic send_request(input edf_pkg::cmd_t c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do @(posedge clk); while (!cmd_ready);
        tracker.note_request(c);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain_results();
        cmd_valid <= 1'b0;
        do @(posedge clk); while (tracker.pending() != 0);
    endtask

    // Accept results after a random stall and check each one
    initial
    begin : result_sink
        int stall;
        res_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
            tracker.check_result(res);
        end
    end

    initial
    begin : stimulus
        int k;
        int p;
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        tick          = '0;
        last_deadline = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty queue: complete and polls do nothing
        send_request(make_request(edf_pkg::CMD_COMPLETE, 8'h11, 32'd0, 16'd0, 32'd7));
        send_request(make_request(edf_pkg::CMD_POLL, 8'h22, 32'd0, 16'd0, 32'd7));
        send_request(make_request(CMD_SPARE, 8'h33, 32'd0, 16'd0, 32'd7));
        // Largest fields, deadline exactly now + exec: accepted
        send_request(make_request(edf_pkg::CMD_RELEASE, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF,
                                  32'hFFFF_0000));
        // Sum beyond 32 bits must not wrap: late
        send_request(make_request(edf_pkg::CMD_RELEASE, 8'h80, 32'hFFFF_FFFF, 16'hFFFF,
                                  32'hFFFF_FFFF));
        // Zero fields go ahead of the head, then a tie lands behind it
        send_request(make_request(edf_pkg::CMD_RELEASE, 8'h00, 32'd0, 16'd0, 32'd0));
        send_request(make_request(edf_pkg::CMD_RELEASE, 8'h01, 32'd0, 16'd0, 32'd0));
        // Fill the queue
        for (k = 0; k < edf_pkg::QUEUE_DEPTH - 3; k++)
            send_request(make_request(edf_pkg::CMD_RELEASE, (edf_pkg::ID_W)'(8'h10 + k),
                                      (edf_pkg::TICK_W)'($urandom_range(1, 1000)),
                                      16'd0, 32'd0));
        // Full queue: a timely release drops, a late one still counts overdue
        send_request(make_request(edf_pkg::CMD_RELEASE, 8'h55, 32'd2000, 16'd0, 32'd0));
        send_request(make_request(edf_pkg::CMD_RELEASE, 8'hAA, 32'd5, 16'd10, 32'd0));
        // Retire the head, then let overdue heads expire on polls
        send_request(make_request(edf_pkg::CMD_COMPLETE, 8'h00, 32'd0, 16'd0, 32'd0));
        send_request(make_request(edf_pkg::CMD_POLL, 8'h00, 32'd0, 16'd0, 32'd1));
        send_request(make_request(CMD_SPARE, 8'h00, 32'd0, 16'd0, 32'd5000));

        // Random schedules: fill-heavy and drain-heavy phases in turn
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0)
                tick = $urandom;
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (p % 2 == 0)
                    send_request(next_event(60, 8));
                else
                    send_request(next_event(20, 40));
            end
            if (p == 0 || $urandom_range(0, 3) == 0)
                drain_results();
        end

        no_idle = 1'b0;
        // Close with mixed traffic under random gaps
        for (k = 0; k < 40; k++)
            send_request(next_event(50, 20));

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("** edf_deadline_scheduler: PASSED **");
        else
            $display("** edf_deadline_scheduler: FAILED **");
        $finish;
    end

endmodule
